>>> src/assert_macros.svh
// Assertion macros shared by the mean/variance reduction RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define MVR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define MVR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MVR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MVR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/mvr_pkg.sv
// Package: types and constants of the mean/variance reduction core.
`timescale 1ns / 1ps
package mvr_pkg;

  localparam int MAX_COLS_DEF    = 1024;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int SUM_BITS       = 32;
  localparam int SQ_BITS        = 48;
  localparam int SQ_HALF_BITS   = SQ_BITS / 2;
  localparam int MEAN_BITS      = 32;
  localparam int VAR_BITS       = 48;
  localparam int RECIP_BITS     = 31;
  localparam int RECIP_ONE_LOG  = 30;
  localparam int CFG_DATA_BITS  = 31;
  localparam int CFG_INDEX_BITS = 2;

  // Product scaling: Q1.30 reciprocal times sum gives 16 fraction bits after >> 14.
  localparam int PROD_SHIFT   = 14;
  localparam int MSQ_SHIFT    = 16;
  localparam int VAR_CAP_LOG  = 62;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_REDUCE_MODE = 2'd0,
    REG_ROW_COUNT   = 2'd1,
    REG_COL_COUNT   = 2'd2,
    REG_RECIP_COUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_MEAN,
    ST_VMUL,
    ST_SQ,
    ST_OUT
  } state_t;

endpackage

>>> src/mvr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module mvr_ram #(
  parameter int WIDTH     = 8,
  parameter int DEPTH     = 16,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/mean_variance_reduction_core.sv
// Top level: streaming per-column or per-row mean and population variance.
// A result beat passes the ACC, MEAN, VMUL, SQ and OUT states after the sample that ends its column/row.
// The block takes one sample at a time and accepts the next only on return to IDLE, which
// takes longer for a sample that emits a result, and more while the output register is
// stalled; set by the one-entry read-modify-write of the column store and the 48x31 product split over MEAN and VMUL.
// Reset (rst_n low at a clock edge): config to defaults, positions and running sums
// cleared, sequencer idle; the column store is not cleared, row zero rewrites it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mean_variance_reduction_core #(
  parameter int MAX_COLS    = mvr_pkg::MAX_COLS_DEF,
  parameter int SAMPLE_BITS = mvr_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = mvr_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [mvr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mvr_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  // sample input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mvr_pkg::MEAN_BITS-1:0] out_mean_value,
  output logic [mvr_pkg::VAR_BITS-1:0]        out_variance_value,
  output logic [COUNT_BITS-1:0]               out_result_index,
  output logic                                out_last_result
);
  import mvr_pkg::*;

  localparam int ADDR_BITS = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RAM_WIDTH = SUM_BITS + SQ_BITS;
  localparam int HALF_PROD = SQ_HALF_BITS + RECIP_BITS;
  localparam int FULL_PROD = SQ_BITS + RECIP_BITS;
  localparam int E_BITS    = VAR_CAP_LOG + 1;
  localparam int SQ_FULL_BITS   = 2 * SAMPLE_BITS;
  localparam int MEAN_PROD_BITS = 2 * MEAN_BITS;

  localparam logic signed [2*MEAN_BITS-1:0] MEAN_MAX =
    (64'sd1 <<< (MEAN_BITS - 1)) - 64'sd1;
  localparam logic signed [2*MEAN_BITS-1:0] MEAN_MIN = -(64'sd1 <<< (MEAN_BITS - 1));
  localparam logic [FULL_PROD-1:0] E_CAP_WIDE = FULL_PROD'(1) << VAR_CAP_LOG;
  localparam logic [E_BITS-1:0]    E_CAP      = E_BITS'(1) << VAR_CAP_LOG;
  localparam logic [E_BITS-1:0]    VAR_MAX_E  = E_BITS'({VAR_BITS{1'b1}});

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                  mode_r;
  logic [COUNT_BITS-1:0] row_count_r;
  logic [COUNT_BITS-1:0] col_count_r;
  logic [RECIP_BITS-1:0] recip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      row_count_r <= COUNT_BITS'(1);
      col_count_r <= COUNT_BITS'(1);
      recip_r     <= RECIP_BITS'(1) << RECIP_ONE_LOG;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REDUCE_MODE: mode_r      <= cfg_wdata[0];
        REG_ROW_COUNT:   row_count_r <= cfg_wdata[COUNT_BITS-1:0];
        REG_COL_COUNT:   col_count_r <= cfg_wdata[COUNT_BITS-1:0];
        REG_RECIP_COUNT: recip_r     <= cfg_wdata[RECIP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: IDLE takes a beat and issues the column read, ACC adds and
  // writes back, MEAN/VMUL/SQ run the multiplies, OUT loads the result register.
  // One item is in flight at a time, so the write-back always lands before the
  // next read of the same column and no forwarding path is needed.
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic in_accept;
  logic emit;
  logic out_free;
  logic acc_en, mean_en, vmul_en, sq_en, out_load;

  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid)  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = emit ? ST_MEAN : ST_IDLE;
      ST_MEAN: state_nxt = ST_VMUL;
      ST_VMUL: state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    acc_en   = 1'b0;
    mean_en  = 1'b0;
    vmul_en  = 1'b0;
    sq_en    = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_ACC:  acc_en   = 1'b1;
      ST_MEAN: mean_en  = 1'b1;
      ST_VMUL: vmul_en  = 1'b1;
      ST_SQ:   sq_en    = 1'b1;
      ST_OUT:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: effective counts, position wrap, square of the sample
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] col_pos_r, row_pos_r;
  logic [COUNT_BITS-1:0] rows_eff, cols_raw, cols_eff;
  logic [COUNT_BITS-1:0] col_cur, row_cur;
  logic                  col_end, row_end;
  logic signed [2*SAMPLE_BITS-1:0] sq_full;

  always_comb begin
    rows_eff = (row_count_r == '0) ? COUNT_BITS'(1) : row_count_r;
    cols_raw = (col_count_r == '0) ? COUNT_BITS'(1) : col_count_r;
    // clamp the column count to the store depth in column mode
    cols_eff = (!mode_r && (32'(cols_raw) > 32'(MAX_COLS))) ? COUNT_BITS'(MAX_COLS)
                                                            : cols_raw;
    col_cur  = (col_pos_r >= cols_eff) ? '0 : col_pos_r;
    row_cur  = (row_pos_r >= rows_eff) ? '0 : row_pos_r;
    col_end  = (col_cur == cols_eff - COUNT_BITS'(1));
    row_end  = (row_cur == rows_eff - COUNT_BITS'(1));
  end

  assign sq_full = SQ_FULL_BITS'(in_sample) * SQ_FULL_BITS'(in_sample);

  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [SQ_BITS-1:0]            sq_r;
  logic [COUNT_BITS-1:0]         col_idx_r, row_idx_r;
  logic                          col_first_r, row_first_r, col_end_r, row_end_r;

  // Advance the positions at accept; they are only read at the next accept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (in_accept) begin
      col_pos_r <= col_end ? '0 : col_cur + COUNT_BITS'(1);
      if (col_end) begin
        row_pos_r <= row_end ? '0 : row_cur + COUNT_BITS'(1);
      end else begin
        row_pos_r <= row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_r    <= in_sample;
      sq_r        <= SQ_BITS'(sq_full);
      col_idx_r   <= col_cur;
      row_idx_r   <= row_cur;
      col_first_r <= (col_cur == '0);
      row_first_r <= (row_cur == '0);
      col_end_r   <= col_end;
      row_end_r   <= row_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Column store: {square sum, sum} per column
  // ---------------------------------------------------------------------------
  logic                 ram_we;
  logic [RAM_WIDTH-1:0] ram_wdata, ram_rdata;

  mvr_ram #(
    .WIDTH (RAM_WIDTH),
    .DEPTH (MAX_COLS)
  ) u_col_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_BITS'(col_idx_r)),
    .wdata (ram_wdata),
    .raddr (ADDR_BITS'(col_cur)),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Accumulate stage
  // ---------------------------------------------------------------------------
  logic [SUM_BITS-1:0] run_sum_r, sum_base, sum_nxt;
  logic [SQ_BITS-1:0]  run_ssum_r, ssum_base, ssum_nxt;

  always_comb begin
    if (mode_r) begin
      sum_base  = col_first_r ? '0 : run_sum_r;
      ssum_base = col_first_r ? '0 : run_ssum_r;
    end else begin
      // the first row starts the column fresh; ignore stale store contents
      sum_base  = row_first_r ? '0 : ram_rdata[SUM_BITS-1:0];
      ssum_base = row_first_r ? '0 : ram_rdata[RAM_WIDTH-1:SUM_BITS];
    end
    sum_nxt  = sum_base + SUM_BITS'(sample_r);
    ssum_nxt = ssum_base + sq_r;
    emit     = mode_r ? col_end_r : row_end_r;
  end

  assign ram_we    = acc_en && !mode_r;
  assign ram_wdata = {ssum_nxt, sum_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_sum_r  <= '0;
      run_ssum_r <= '0;
    end else if (acc_en && mode_r) begin
      run_sum_r  <= sum_nxt;
      run_ssum_r <= ssum_nxt;
    end
  end

  logic [SUM_BITS-1:0]   acc_sum_r;
  logic [SQ_BITS-1:0]    acc_ssum_r;
  logic [COUNT_BITS-1:0] res_idx_r;
  logic                  res_last_r;

  always_ff @(posedge clk) begin
    if (acc_en && emit) begin
      acc_sum_r  <= sum_nxt;
      acc_ssum_r <= ssum_nxt;
      res_idx_r  <= mode_r ? row_idx_r : col_idx_r;
      res_last_r <= mode_r ? row_end_r : col_end_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply stages
  // MEAN: sum * recip and low half of square sum * recip
  // VMUL: high half of square sum * recip; scale and saturate the mean
  // SQ:   squared mean, combine the square-sum halves and cap
  // ---------------------------------------------------------------------------
  logic signed [2*MEAN_BITS-1:0] mean_prod_r, mean_shift;
  logic [HALF_PROD-1:0]          lo_prod_r, hi_prod_r;
  logic signed [MEAN_BITS-1:0]   mean_r, mean_sat;
  logic [MEAN_BITS-1:0]          mean_mag;
  logic [2*MEAN_BITS-1:0]        mean_sq;
  logic [VAR_BITS-1:0]           msq_r;
  logic [FULL_PROD-1:0]          p_full, e_wide;
  logic [E_BITS-1:0]             e_r;

  always_comb begin
    // arithmetic shift floors toward minus infinity for negative products
    mean_shift = mean_prod_r >>> PROD_SHIFT;
    if (mean_shift > MEAN_MAX) begin
      mean_sat = MEAN_BITS'(MEAN_MAX);
    end else if (mean_shift < MEAN_MIN) begin
      mean_sat = MEAN_BITS'(MEAN_MIN);
    end else begin
      mean_sat = MEAN_BITS'(mean_shift);
    end
    mean_mag = mean_r[MEAN_BITS-1] ? MEAN_BITS'(-mean_r) : MEAN_BITS'(mean_r);
    mean_sq  = MEAN_PROD_BITS'(mean_mag) * MEAN_PROD_BITS'(mean_mag);
    p_full   = {hi_prod_r, {SQ_HALF_BITS{1'b0}}} + FULL_PROD'(lo_prod_r);
    e_wide   = p_full >> PROD_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (mean_en) begin
      mean_prod_r <= MEAN_PROD_BITS'($signed(acc_sum_r)) *
                     MEAN_PROD_BITS'($signed({1'b0, recip_r}));
      lo_prod_r   <= HALF_PROD'(acc_ssum_r[SQ_HALF_BITS-1:0]) * HALF_PROD'(recip_r);
    end
    if (vmul_en) begin
      hi_prod_r <= HALF_PROD'(acc_ssum_r[SQ_BITS-1:SQ_HALF_BITS]) * HALF_PROD'(recip_r);
      mean_r    <= mean_sat;
    end
    if (sq_en) begin
      msq_r <= mean_sq[2*MEAN_BITS-1:MSQ_SHIFT];
      e_r   <= (e_wide > E_CAP_WIDE) ? E_CAP : E_BITS'(e_wide);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: variance = E - M, clamped to [0, 2^48-1]
  // ---------------------------------------------------------------------------
  logic [E_BITS-1:0]   msq_ext, var_diff;
  logic [VAR_BITS-1:0] var_val;

  always_comb begin
    msq_ext  = E_BITS'(msq_r);
    var_diff = e_r - msq_ext;
    if (e_r <= msq_ext) begin
      var_val = '0;
    end else if (var_diff > VAR_MAX_E) begin
      var_val = '1;
    end else begin
      var_val = VAR_BITS'(var_diff);
    end
  end

  logic                        out_valid_r;
  logic signed [MEAN_BITS-1:0] out_mean_r;
  logic [VAR_BITS-1:0]         out_var_r;
  logic [COUNT_BITS-1:0]       out_idx_r;
  logic                        out_last_r;

  // Hold the beat until taken; drop valid on take unless a new one loads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mean_r <= mean_r;
      out_var_r  <= var_val;
      out_idx_r  <= res_idx_r;
      out_last_r <= res_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mean_value     = out_mean_r;
  assign out_variance_value = out_var_r;
  assign out_result_index   = out_idx_r;
  assign out_last_result    = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `MVR_ASSERT_NXT(a_accept_to_acc, clk, rst_n, in_accept, state_r == ST_ACC, "beat not taken up")
  `MVR_ASSERT_IMP(a_valid_rise, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_OUT, "bad rise")
  `MVR_ASSERT_NXT(a_out_load, clk, rst_n, out_load, out_valid_r && (state_r == ST_IDLE), "no load")
  `MVR_ASSERT_IMP(a_ram_we_acc, clk, rst_n, ram_we, $past(in_accept), "store write without a beat")

endmodule

>>> tb/sv/mean_variance_reduction_core_tb.sv
// Self-checking testbench for the streaming mean/variance reduction core.
`timescale 1ns / 1ps
module mean_variance_reduction_core_tb;
  import mvr_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 600000;
  // Results trail their closing sample through the ACC, MEAN, VMUL, SQ and OUT states; leave margin on top.
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic signed [MEAN_BITS-1:0] mean;
    logic [VAR_BITS-1:0]         variance;
    logic [COUNT_BITS_DEF-1:0]   index;
    logic                        is_last;
  } stats_t;

  typedef enum bit {PLAN_CFG, PLAN_SAMPLE} plan_kind_t;

  typedef struct {
    plan_kind_t                        kind;
    cfg_reg_t                          addr;
    logic [CFG_DATA_BITS-1:0]          data;
    logic signed [SAMPLE_BITS_DEF-1:0] sample;
    bit                                typed;
    stats_t                            want;
  } plan_row_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0]          cfg_index = REG_REDUCE_MODE;
  logic [CFG_DATA_BITS-1:0]           cfg_wdata = '0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic signed [SAMPLE_BITS_DEF-1:0]  in_sample = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [MEAN_BITS-1:0]        out_mean_value;
  logic [VAR_BITS-1:0]                out_variance_value;
  logic [COUNT_BITS_DEF-1:0]          out_result_index;
  logic                               out_last_result;

  mean_variance_reduction_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_mean_value     (out_mean_value),
    .out_variance_value (out_variance_value),
    .out_result_index   (out_result_index),
    .out_last_result    (out_last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the registers, the column store and the
  // row accumulators. col_seen marks column entries that hold a real value, so
  // the stimulus never makes the block read an entry that was never written.
  // ---------------------------------------------------------------------------
  bit                 st_mode;
  bit [15:0]          st_rows;
  bit [15:0]          st_cols;
  bit [RECIP_BITS-1:0] st_recip;
  bit [SUM_BITS-1:0]  col_sum   [MAX_COLS_DEF];
  bit [SQ_BITS-1:0]   col_sqsum [MAX_COLS_DEF];
  bit                 col_seen  [MAX_COLS_DEF];
  bit [SUM_BITS-1:0]  row_sum;
  bit [SQ_BITS-1:0]   row_sqsum;
  bit [15:0]          pos_row;
  bit [15:0]          pos_col;

  stats_t pending [$];   // expected result beats, oldest first
  int     err_count  = 0;
  int     beats_seen = 0;
  int     sent_count = 0;

  // Zero counts act as one; column mode cannot track more than the store holds.
  function automatic int unsigned eff_cols(input bit mode, input bit [15:0] cols);
    int unsigned n;
    n = (cols == 0) ? 1 : cols;
    if (mode == 1'b0 && n > MAX_COLS_DEF) n = MAX_COLS_DEF;
    return n;
  endfunction

  // Sum times the Q1.30 reciprocal, 16 fraction bits, rounded toward minus
  // infinity and saturated to 32 bits.
  function automatic logic signed [MEAN_BITS-1:0] scaled_mean(input bit [SUM_BITS-1:0] s);
    longint p;
    longint q;
    p = longint'($signed(s)) * longint'(st_recip);
    if (p >= 0) q = p >>> PROD_SHIFT;
    else q = -((-p + 64'sd16383) >>> PROD_SHIFT);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[MEAN_BITS-1:0];
  endfunction

  // Mean of squares minus squared mean, clamped to [0, 2^48-1]. The product
  // is split at bit 15 of the reciprocal so no term leaves 64 bits.
  function automatic logic [VAR_BITS-1:0] scaled_variance(input bit [SQ_BITS-1:0] ss,
                                                          input logic signed [MEAN_BITS-1:0] m);
    bit [63:0] ss64;
    bit [63:0] hi;
    bit [63:0] lo;
    bit [63:0] e;
    bit [63:0] mag;
    bit [63:0] msq;
    bit [63:0] cap;
    longint    lm;
    cap  = 64'd1 << VAR_CAP_LOG;
    ss64 = 64'(ss);
    hi   = ss64 * 64'(st_recip >> 15);
    lo   = ss64 * 64'(st_recip & 31'h7FFF);
    if (hi >= (64'd1 << 61)) begin
      e = cap;
    end else begin
      e = 2 * hi + (lo >> PROD_SHIFT);
      if (e > cap) e = cap;
    end
    lm  = m;
    mag = (lm < 0) ? 64'(-lm) : 64'(lm);
    msq = (mag * mag) >> MSQ_SHIFT;
    if (e <= msq) return '0;
    e = e - msq;
    if (e > 64'hFFFF_FFFF_FFFF) e = 64'hFFFF_FFFF_FFFF;
    return e[VAR_BITS-1:0];
  endfunction

  // Fold one accepted sample into the predictor; return 1 with the result
  // when this sample closes a column (mode 0) or a row (mode 1).
  function automatic bit fold_sample(input logic signed [SAMPLE_BITS_DEF-1:0] x,
                                     output stats_t res);
    longint         sx;
    bit [63:0]      ux;
    bit [63:0]      sq;
    int unsigned    rows;
    int unsigned    cols;
    int unsigned    r;
    int unsigned    c;
    bit [SUM_BITS-1:0] s;
    bit [SQ_BITS-1:0]  ss;
    bit             emit;
    bit             last;
    int unsigned    idx;
    sx   = x;
    ux   = 64'(sx);
    sq   = ux * ux;
    rows = (st_rows == 0) ? 1 : st_rows;
    cols = eff_cols(st_mode, st_cols);
    // Positions left beyond a shrunken count restart at zero.
    if (pos_col >= cols) pos_col = 0;
    if (pos_row >= rows) pos_row = 0;
    r    = pos_row;
    c    = pos_col;
    last = 1'b0;
    idx  = 0;
    if (st_mode == 1'b0) begin
      if (r == 0) begin
        s  = ux[SUM_BITS-1:0];
        ss = sq[SQ_BITS-1:0];
      end else begin
        s  = col_sum[c] + ux[SUM_BITS-1:0];
        ss = col_sqsum[c] + sq[SQ_BITS-1:0];
      end
      col_sum[c]   = s;
      col_sqsum[c] = ss;
      col_seen[c]  = 1'b1;
      emit = (r == rows - 1);
      if (emit) begin
        idx  = c;
        last = (c == cols - 1);
      end
    end else begin
      if (c == 0) begin
        s  = ux[SUM_BITS-1:0];
        ss = sq[SQ_BITS-1:0];
      end else begin
        s  = row_sum + ux[SUM_BITS-1:0];
        ss = row_sqsum + sq[SQ_BITS-1:0];
      end
      row_sum   = s;
      row_sqsum = ss;
      emit = (c == cols - 1);
      if (emit) begin
        idx  = r;
        last = (r == rows - 1);
      end
    end
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    pos_col = c[15:0];
    pos_row = r[15:0];
    res.mean     = scaled_mean(s);
    res.variance = scaled_variance(ss, res.mean);
    res.index    = idx[15:0];
    res.is_last  = last;
    return emit;
  endfunction

  function automatic void note_mismatch(input string field, input longint want,
                                        input longint got);
    err_count++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endfunction

  function automatic logic signed [SAMPLE_BITS_DEF-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($signed($urandom_range(16)) - 8);
      3: return ($urandom_range(1) == 0) ? 16'sd0 : -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_count();
    case ($urandom_range(19))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'(MAX_COLS_DEF + $urandom_range(1));
      3: return 16'($urandom);
      default: return 16'($urandom_range(6, 1));
    endcase
  endfunction

  function automatic plan_row_t plan_cfg(input cfg_reg_t addr, input logic [30:0] data);
    plan_row_t p;
    p = '{PLAN_CFG, addr, data, 16'sd0, 1'b0, '{32'sd0, 48'd0, 16'd0, 1'b0}};
    return p;
  endfunction

  function automatic plan_row_t plan_smp(input logic signed [15:0] x);
    plan_row_t p;
    p = '{PLAN_SAMPLE, REG_REDUCE_MODE, 31'd0, x, 1'b0, '{32'sd0, 48'd0, 16'd0, 1'b0}};
    return p;
  endfunction

  function automatic plan_row_t plan_typed(input logic signed [15:0] x,
                                           input logic signed [31:0] mean);
    plan_row_t p;
    // Every typed row is a single-sample matrix: variance zero, index zero, last.
    p = '{PLAN_SAMPLE, REG_REDUCE_MODE, 31'd0, x, 1'b1, '{mean, 48'd0, 16'd0, 1'b1}};
    return p;
  endfunction

  // Present one sample and hold it until the block takes it; then advance
  // the predictor and queue the result it calls for.
  task automatic push_sample(input logic signed [SAMPLE_BITS_DEF-1:0] x, input bit typed,
                             input stats_t want);
    int unsigned gap;
    stats_t      model;
    gap = 0;
    // Steady stretch on the feed side: no gaps at all.
    if (!(sent_count >= 900 && sent_count < 1150) && $urandom_range(99) < 15)
      gap = $urandom_range(4, 1);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= x;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    if (fold_sample(x, model)) pending.push_back(typed ? want : model);
  endtask

  // Drop valid, drain every expected beat, then let trailing work finish.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t addr, input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      REG_REDUCE_MODE: st_mode  = data[0];
      REG_ROW_COUNT:   st_rows  = data[15:0];
      REG_COL_COUNT:   st_cols  = data[15:0];
      REG_RECIP_COUNT: st_recip = data[RECIP_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each beat against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    stats_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      if (pending.size() == 0) begin
        err_count++;
        $error("result beat with no expectation waiting (index %0d)", out_result_index);
      end else begin
        want = pending.pop_front();
        if (out_mean_value !== want.mean)
          note_mismatch("mean_value", want.mean, out_mean_value);
        if (out_variance_value !== want.variance)
          note_mismatch("variance_value", want.variance, out_variance_value);
        if (out_result_index !== want.index)
          note_mismatch("result_index", want.index, out_result_index);
        if (out_last_result !== want.is_last)
          note_mismatch("last_result", want.is_last, out_last_result);
      end
    end
  end

  // Drive ready: random stalls, a stretch with none, and one long hold-off
  // taken while a sample is on offer so the block backs up into its input.
  initial begin : result_sink
    int unsigned hold_left;
    bit          pressure_done;
    hold_left     = 0;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!pressure_done && beats_seen >= 200 && in_valid) begin
        pressure_done = 1'b1;
        hold_left     = 399;
        out_ready     <= 1'b0;
      end else if (beats_seen >= 60 && beats_seen < 180) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 15);
      end
    end
  end

  initial begin : watchdog
    int unsigned n;
    n = 0;
    while (n < CYCLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    $display("mean_variance_reduction_core_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed table, then random phases of configuration and samples.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t     plan [$];
    stats_t        none;
    bit            wr [4];
    logic [30:0]   cand [4];
    bit            eff_mode;
    bit [15:0]     eff_rows;
    bit [15:0]     eff_cnt;
    int unsigned   rows_e;
    int unsigned   cols_e;
    int unsigned   r_e;
    int unsigned   c_e;
    int unsigned   len;
    longint        size;
    longint        n;
    bit            safe;
    int            random_sent;

    none = '{32'sd0, 48'd0, 16'd0, 1'b0};
    // Mirror the reset state; the column store is unknown and left unmarked.
    st_mode   = 1'b0;
    st_rows   = 16'd1;
    st_cols   = 16'd1;
    st_recip  = 31'd1 << RECIP_ONE_LOG;
    row_sum   = '0;
    row_sqsum = '0;
    pos_row   = '0;
    pos_col   = '0;
    foreach (col_seen[i]) col_seen[i] = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Defaults: every sample is a 1x1 matrix, mean is x << 16, variance zero.
    plan.push_back(plan_typed(16'sh7FFF, 32'sh7FFF0000));
    plan.push_back(plan_typed(16'sh8000, 32'sh80000000));
    plan.push_back(plan_typed(16'sd0, 32'sd0));
    plan.push_back(plan_typed(-16'sd1, 32'shFFFF0000));
    // Zero reciprocal: everything collapses to zero.
    plan.push_back(plan_cfg(REG_RECIP_COUNT, 31'd0));
    plan.push_back(plan_typed(16'sd12345, 32'sd0));
    // Reciprocal just under two: mean saturates both ways.
    plan.push_back(plan_cfg(REG_RECIP_COUNT, 31'h7FFFFFFF));
    plan.push_back(plan_smp(16'sh7FFF));
    plan.push_back(plan_smp(16'sh8000));
    // Row mode, 2x2, divide by two.
    plan.push_back(plan_cfg(REG_REDUCE_MODE, 31'd1));
    plan.push_back(plan_cfg(REG_ROW_COUNT, 31'd2));
    plan.push_back(plan_cfg(REG_COL_COUNT, 31'd2));
    plan.push_back(plan_cfg(REG_RECIP_COUNT, 31'd1 << 29));
    plan.push_back(plan_smp(16'sd100));
    plan.push_back(plan_smp(-16'sd300));
    plan.push_back(plan_smp(16'sh7FFF));
    plan.push_back(plan_smp(16'sh7FFF));
    // Column mode, 2 rows by 3 columns.
    plan.push_back(plan_cfg(REG_REDUCE_MODE, 31'd0));
    plan.push_back(plan_cfg(REG_COL_COUNT, 31'd3));
    plan.push_back(plan_smp(16'sh8000));
    plan.push_back(plan_smp(16'sd7));
    plan.push_back(plan_smp(16'sh7FFF));
    plan.push_back(plan_smp(16'sh8000));
    plan.push_back(plan_smp(-16'sd9));
    plan.push_back(plan_smp(16'sh7FFF));
    // Zero counts behave as one.
    plan.push_back(plan_cfg(REG_REDUCE_MODE, 31'd1));
    plan.push_back(plan_cfg(REG_ROW_COUNT, 31'd0));
    plan.push_back(plan_cfg(REG_COL_COUNT, 31'd0));
    plan.push_back(plan_smp(16'sd1234));
    plan.push_back(plan_smp(-16'sd4321));
    // Column mode clamps a wide matrix to the store size.
    plan.push_back(plan_cfg(REG_REDUCE_MODE, 31'd0));
    plan.push_back(plan_cfg(REG_ROW_COUNT, 31'd1));
    plan.push_back(plan_cfg(REG_COL_COUNT, 31'd2000));
    plan.push_back(plan_cfg(REG_RECIP_COUNT, 31'd1 << 30));
    plan.push_back(plan_smp(16'sd55));
    plan.push_back(plan_smp(-16'sd55));
    // Widest counts in row mode, then shrink so the column position restarts.
    plan.push_back(plan_cfg(REG_REDUCE_MODE, 31'd1));
    plan.push_back(plan_cfg(REG_ROW_COUNT, 31'hFFFF));
    plan.push_back(plan_cfg(REG_COL_COUNT, 31'hFFFF));
    plan.push_back(plan_smp(16'sd3));
    plan.push_back(plan_smp(16'sd4));
    plan.push_back(plan_cfg(REG_COL_COUNT, 31'd2));
    plan.push_back(plan_smp(16'sh7FFF));
    plan.push_back(plan_smp(16'sh8000));

    foreach (plan[i]) begin
      if (plan[i].kind == PLAN_CFG) begin
        settle();
        write_reg(plan[i].addr, plan[i].data);
      end else begin
        push_sample(plan[i].sample, plan[i].typed, plan[i].want);
      end
    end

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      for (int i = 0; i < 4; i++) wr[i] = ($urandom_range(3) != 0);
      cand[REG_REDUCE_MODE] = ($urandom_range(9) == 0) ? 31'($urandom) :
                              31'($urandom_range(1));
      cand[REG_ROW_COUNT]   = {15'd0, pick_count()};
      cand[REG_COL_COUNT]   = {15'd0, pick_count()};
      // Upper bits of a count write are junk the block must ignore.
      if ($urandom_range(9) == 0) cand[REG_ROW_COUNT][30:16] = 15'($urandom);
      if ($urandom_range(9) == 0) cand[REG_COL_COUNT][30:16] = 15'($urandom);

      eff_mode = wr[REG_REDUCE_MODE] ? cand[REG_REDUCE_MODE][0] : st_mode;
      eff_rows = wr[REG_ROW_COUNT] ? cand[REG_ROW_COUNT][15:0] : st_rows;
      eff_cnt  = wr[REG_COL_COUNT] ? cand[REG_COL_COUNT][15:0] : st_cols;

      // Column mode must not start mid-matrix over entries never written.
      if (eff_mode == 1'b0) begin
        cols_e = eff_cols(1'b0, eff_cnt);
        rows_e = (eff_rows == 0) ? 1 : eff_rows;
        c_e    = (pos_col >= cols_e) ? 0 : pos_col;
        r_e    = (pos_row >= rows_e) ? 0 : pos_row;
        safe   = (c_e == 0 && r_e == 0);
        if (!safe) begin
          safe = 1'b1;
          for (int k = 0; k < cols_e; k++) if (!col_seen[k]) safe = 1'b0;
        end
        if (!safe) begin
          eff_mode               = 1'b1;
          wr[REG_REDUCE_MODE]    = 1'b1;
          cand[REG_REDUCE_MODE][0] = 1'b1;
        end
      end

      cols_e = eff_cols(eff_mode, eff_cnt);
      rows_e = (eff_rows == 0) ? 1 : eff_rows;
      len    = (eff_mode == 1'b0) ? rows_e : cols_e;
      case ($urandom_range(19))
        0: cand[REG_RECIP_COUNT] = 31'd0;
        1: cand[REG_RECIP_COUNT] = 31'h7FFFFFFF;
        2: cand[REG_RECIP_COUNT] = 31'($urandom);
        default: cand[REG_RECIP_COUNT] = 31'((32'd1 << RECIP_ONE_LOG) / len);
      endcase

      settle();
      for (int i = 0; i < 4; i++) if (wr[i]) write_reg(cfg_reg_t'(i), cand[i]);

      // Mostly run whole matrices from wherever the block stands; now and
      // then a ragged burst that leaves it mid-matrix.
      c_e  = (pos_col >= cols_e) ? 0 : pos_col;
      r_e  = (pos_row >= rows_e) ? 0 : pos_row;
      size = longint'(rows_e) * longint'(cols_e);
      if (size <= 96 && $urandom_range(4) != 0)
        n = size - (longint'(r_e) * cols_e + c_e) + longint'($urandom_range(2)) * size;
      else
        n = $urandom_range(40, 1);
      for (longint k = 0; k < n; k++) push_sample(rand_sample(), 1'b0, none);
      random_sent += int'(n);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4 * DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending.size() == 0)
      $display("mean_variance_reduction_core_tb: PASS");
    else
      $display("mean_variance_reduction_core_tb: FAIL");
    $finish;
  end

endmodule
